// ===== rtl/core/bsrc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bsrc_pkg
// Shared types and constants of the box shape rule check unit.
// ---------------------------------------------------------------------------
package bsrc_pkg;

    // Datapath widths
    localparam int MAG_W      = 17;             // clamped |dx|, |dy|
    localparam int SQ_W       = 2 * MAG_W;      // squared sum
    localparam int ROOT_W     = 17;             // raw root before saturation
    localparam int REM_W      = ROOT_W + 3;     // root remainder
    localparam int SQRT_STEPS = SQ_W / 2;       // one result bit per step
    localparam int LEN_W      = 16;             // Q8.8 edge length
    localparam int AREA_W     = 2 * LEN_W;      // Q16.16 area
    localparam int HGT_W      = 17;             // exact height sum
    localparam int MASS_W     = AREA_W + 1 + HGT_W;
    localparam int CMP_W      = 54;             // point test compare width
    localparam int PTS_W      = 16;

    // Rule constants
    localparam logic [MAG_W-1:0] MAG_CLAMP  = 17'd65536;
    localparam logic [PTS_W-1:0] MIN_POINTS = 16'd25;
    localparam logic [LEN_W-1:0] RATIO_LEN  = 16'd768;   // 3.0 m in Q8.8
    localparam int               PTS_SHIFT  = 24;
    localparam int               MASS_SHIFT = 3;         // 8 points per m^3

    // APB register map
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    typedef enum logic [2:0] {
        REG_HEIGHT_MIN   = 3'd0,
        REG_HEIGHT_MAX   = 3'd1,
        REG_WIDTH_MIN    = 3'd2,
        REG_WIDTH_MAX    = 3'd3,
        REG_LENGTH_MIN   = 3'd4,
        REG_LENGTH_MAX   = 3'd5,
        REG_AREA_MAX     = 3'd6,
        REG_SENSOR_MOUNT = 3'd7
    } t_bsrc_reg;

    // Register reset values
    localparam logic [15:0] RST_HEIGHT_MIN   = 16'd256;
    localparam logic [15:0] RST_HEIGHT_MAX   = 16'd666;
    localparam logic [15:0] RST_WIDTH_MIN    = 16'd64;
    localparam logic [15:0] RST_WIDTH_MAX    = 16'd512;
    localparam logic [15:0] RST_LENGTH_MIN   = 16'd128;
    localparam logic [15:0] RST_LENGTH_MAX   = 16'd1280;
    localparam logic [31:0] RST_AREA_MAX     = 32'd327680;
    localparam logic [15:0] RST_SENSOR_MOUNT = 16'd384;

    // Configuration seen by the datapath
    typedef struct packed {
        logic signed [15:0] height_min;
        logic signed [15:0] height_max;
        logic [15:0]        width_min;
        logic [15:0]        width_max;
        logic [15:0]        length_min;
        logic [15:0]        length_max;
        logic [31:0]        area_max;
        logic signed [15:0] sensor_mount_height;
    } t_bsrc_cfg;

    // Per-item data riding alongside the edge computation
    typedef struct packed {
        logic                     pts_ok;
        logic                     hgt_ok;
        logic signed [HGT_W-1:0]  height;
        logic [PTS_W-1:0]         npts;
    } t_bsrc_side;

endpackage
`default_nettype wire

// ===== rtl/core/bsrc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bsrc_if
// Valid/ready channels of the box shape rule check unit: cluster in, verdict out.
// ---------------------------------------------------------------------------
interface bsrc_in_if #(
    parameter int COORD_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] corner_a_x;
    logic signed [COORD_WIDTH-1:0] corner_a_y;
    logic signed [COORD_WIDTH-1:0] corner_b_x;
    logic signed [COORD_WIDTH-1:0] corner_b_y;
    logic signed [COORD_WIDTH-1:0] corner_c_x;
    logic signed [COORD_WIDTH-1:0] corner_c_y;
    logic signed [15:0]            top_height;
    logic [15:0]                   point_count;

    modport source (
        output valid, corner_a_x, corner_a_y, corner_b_x, corner_b_y,
               corner_c_x, corner_c_y, top_height, point_count,
        input  ready
    );
    modport sink (
        input  valid, corner_a_x, corner_a_y, corner_b_x, corner_b_y,
               corner_c_x, corner_c_y, top_height, point_count,
        output ready
    );
endinterface

interface bsrc_out_if;
    logic        valid;
    logic        ready;
    logic        promising;
    logic [15:0] box_length;
    logic [15:0] box_width;

    modport source (
        output valid, promising, box_length, box_width,
        input  ready
    );
    modport sink (
        input  valid, promising, box_length, box_width,
        output ready
    );
endinterface
`default_nettype wire

// ===== rtl/core/bsrc_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bsrc_cfg_regs
// APB register file holding the shape rule bounds and sensor mount height.
// ---------------------------------------------------------------------------
module bsrc_cfg_regs
    import bsrc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output t_bsrc_cfg               o_cfg
);

    t_bsrc_cfg r_cfg;
    t_bsrc_reg w_sel;
    logic      w_wr;

    assign w_sel  = t_bsrc_reg'(paddr[PADDR_W-1:2]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Register writes on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.height_min          <= RST_HEIGHT_MIN;
            r_cfg.height_max          <= RST_HEIGHT_MAX;
            r_cfg.width_min           <= RST_WIDTH_MIN;
            r_cfg.width_max           <= RST_WIDTH_MAX;
            r_cfg.length_min          <= RST_LENGTH_MIN;
            r_cfg.length_max          <= RST_LENGTH_MAX;
            r_cfg.area_max            <= RST_AREA_MAX;
            r_cfg.sensor_mount_height <= RST_SENSOR_MOUNT;
        end else if (w_wr) begin
            case (w_sel)
                REG_HEIGHT_MIN:   r_cfg.height_min          <= pwdata[15:0];
                REG_HEIGHT_MAX:   r_cfg.height_max          <= pwdata[15:0];
                REG_WIDTH_MIN:    r_cfg.width_min           <= pwdata[15:0];
                REG_WIDTH_MAX:    r_cfg.width_max           <= pwdata[15:0];
                REG_LENGTH_MIN:   r_cfg.length_min          <= pwdata[15:0];
                REG_LENGTH_MAX:   r_cfg.length_max          <= pwdata[15:0];
                REG_AREA_MAX:     r_cfg.area_max            <= pwdata;
                REG_SENSOR_MOUNT: r_cfg.sensor_mount_height <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (w_sel)
            REG_HEIGHT_MIN:   prdata = {16'd0, r_cfg.height_min};
            REG_HEIGHT_MAX:   prdata = {16'd0, r_cfg.height_max};
            REG_WIDTH_MIN:    prdata = {16'd0, r_cfg.width_min};
            REG_WIDTH_MAX:    prdata = {16'd0, r_cfg.width_max};
            REG_LENGTH_MIN:   prdata = {16'd0, r_cfg.length_min};
            REG_LENGTH_MAX:   prdata = {16'd0, r_cfg.length_max};
            REG_AREA_MAX:     prdata = r_cfg.area_max;
            REG_SENSOR_MOUNT: prdata = {16'd0, r_cfg.sensor_mount_height};
            default:          prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/core/bsrc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bsrc_front
// Three stages: clamped corner deltas and height, squares, squared edge sums.
// ---------------------------------------------------------------------------
module bsrc_front
    import bsrc_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_vld,
    input  wire logic signed [COORD_WIDTH-1:0] i_ax,
    input  wire logic signed [COORD_WIDTH-1:0] i_ay,
    input  wire logic signed [COORD_WIDTH-1:0] i_bx,
    input  wire logic signed [COORD_WIDTH-1:0] i_by,
    input  wire logic signed [COORD_WIDTH-1:0] i_cx,
    input  wire logic signed [COORD_WIDTH-1:0] i_cy,
    input  wire logic signed [15:0]            i_top,
    input  wire logic [PTS_W-1:0]              i_npts,
    input  wire t_bsrc_cfg                     i_cfg,
    output logic                               o_vld,
    output logic [SQ_W-1:0]                    o_sum1,
    output logic [SQ_W-1:0]                    o_sum2,
    output t_bsrc_side                         o_side
);

    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int WIDE_W = (DIFF_W > MAG_W) ? DIFF_W : MAG_W;

    // |p - q| clamped to 65536
    function automatic logic [MAG_W-1:0] clamp_mag(
        input logic signed [COORD_WIDTH-1:0] p,
        input logic signed [COORD_WIDTH-1:0] q
    );
        logic signed [DIFF_W-1:0] d;
        logic [DIFF_W-1:0]        m;
        logic [WIDE_W-1:0]        w;
        d = DIFF_W'(p) - DIFF_W'(q);
        m = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
        w = WIDE_W'(m);
        return (w > WIDE_W'(MAG_CLAMP)) ? MAG_CLAMP : w[MAG_W-1:0];
    endfunction

    logic [2:0]              r_vld;
    logic [MAG_W-1:0]        r_mag [4];
    logic signed [HGT_W-1:0] r_height1;
    logic [PTS_W-1:0]        r_npts1;
    logic [SQ_W-1:0]         r_sq [4];
    t_bsrc_side              r_side2;
    logic [SQ_W-1:0]         r_sum1;
    logic [SQ_W-1:0]         r_sum2;
    t_bsrc_side              r_side3;
    t_bsrc_side              n_side2;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    // Stage 1: deltas, magnitudes, object height
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag[0]  <= clamp_mag(i_ax, i_bx);
            r_mag[1]  <= clamp_mag(i_ay, i_by);
            r_mag[2]  <= clamp_mag(i_cx, i_bx);
            r_mag[3]  <= clamp_mag(i_cy, i_by);
            r_height1 <= HGT_W'(i_top) + HGT_W'(i_cfg.sensor_mount_height);
            r_npts1   <= i_npts;
        end
    end

    // Stage 2 side flags: point floor and height band
    always_comb begin
        n_side2.pts_ok = (r_npts1 >= MIN_POINTS);
        n_side2.hgt_ok = (r_height1 > HGT_W'(i_cfg.height_min)) &&
                         (r_height1 < HGT_W'(i_cfg.height_max));
        n_side2.height = r_height1;
        n_side2.npts   = r_npts1;
    end

    // Stage 2: squares
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 4; i++) begin
                r_sq[i] <= SQ_W'(r_mag[i]) * SQ_W'(r_mag[i]);
            end
            r_side2 <= n_side2;
        end
    end

    // Stage 3: squared edge lengths
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum1  <= r_sq[0] + r_sq[1];
            r_sum2  <= r_sq[2] + r_sq[3];
            r_side3 <= r_side2;
        end
    end

    assign o_vld  = r_vld[2];
    assign o_sum1 = r_sum1;
    assign o_sum2 = r_sum2;
    assign o_side = r_side3;

endmodule
`default_nettype wire

// ===== rtl/core/bsrc_isqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bsrc_isqrt
// Pipelined integer square root, one result bit per stage (floor root).
// ---------------------------------------------------------------------------
module bsrc_isqrt
    import bsrc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [SQ_W-1:0]   i_n,
    output logic      [ROOT_W-1:0] o_root
);

    logic [SQ_W-1:0]   r_n    [SQRT_STEPS];
    logic [REM_W-1:0]  r_rem  [SQRT_STEPS];
    logic [ROOT_W-1:0] r_root [SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        logic [SQ_W-1:0]   w_n;
        logic [REM_W-1:0]  w_rem;
        logic [ROOT_W-1:0] w_root;
        logic [REM_W-1:0]  w_cur;
        logic [REM_W-1:0]  w_trial;
        logic [REM_W-1:0]  n_rem;
        logic [ROOT_W-1:0] n_root;

        if (k == 0) begin : g_first
            assign w_n    = i_n;
            assign w_rem  = '0;
            assign w_root = '0;
        end else begin : g_next
            assign w_n    = r_n[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_root = r_root[k-1];
        end

        // Bring down the next pair of bits, try root*4+1
        always_comb begin
            w_cur   = {w_rem[REM_W-3:0], w_n[SQ_W-1-2*k -: 2]};
            w_trial = REM_W'({w_root, 2'b01});
            if (w_cur >= w_trial) begin
                n_rem  = w_cur - w_trial;
                n_root = {w_root[ROOT_W-2:0], 1'b1};
            end else begin
                n_rem  = w_cur;
                n_root = {w_root[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[k]    <= w_n;
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
            end
        end
    end

    assign o_root = r_root[SQRT_STEPS-1];

endmodule
`default_nettype wire

// ===== rtl/core/bsrc_rules.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bsrc_rules
// Four stages: edge saturation and ordering, area and band checks, point
// density product, final verdict into the output register.
// ---------------------------------------------------------------------------
module bsrc_rules
    import bsrc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_vld,
    input  wire logic [ROOT_W-1:0] i_root1,
    input  wire logic [ROOT_W-1:0] i_root2,
    input  wire t_bsrc_side        i_side,
    input  wire t_bsrc_cfg         i_cfg,
    output logic                   o_vld,
    output logic                   o_promising,
    output logic [LEN_W-1:0]       o_length,
    output logic [LEN_W-1:0]       o_width
);

    logic [3:0]               r_vld;
    // stage 1
    logic [LEN_W-1:0]         r_len1, r_wid1;
    t_bsrc_side               r_side1;
    logic [LEN_W-1:0]         w_e1, w_e2;
    // stage 2
    logic [LEN_W-1:0]         r_len2, r_wid2;
    logic [AREA_W-1:0]        r_area2;
    logic                     r_base2;
    logic                     r_long2;
    logic                     r_ratio2;
    t_bsrc_side               r_side2;
    logic [LEN_W+4:0]         w_len10, w_wid13;
    logic [LEN_W+2:0]         w_len, w_wid5;
    // stage 3
    logic [LEN_W-1:0]         r_len3, r_wid3;
    logic signed [MASS_W-1:0] r_mass3;
    logic                     r_pre3;
    logic [PTS_W-1:0]         r_npts3;
    // stage 4
    logic                     r_ok4;
    logic [LEN_W-1:0]         r_len4, r_wid4;
    logic signed [CMP_W-1:0]  w_lhs, w_rhs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_vld};
        end
    end

    // Stage 1: saturate roots, order into length and width
    assign w_e1 = i_root1[ROOT_W-1] ? {LEN_W{1'b1}} : i_root1[LEN_W-1:0];
    assign w_e2 = i_root2[ROOT_W-1] ? {LEN_W{1'b1}} : i_root2[LEN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_len1  <= (w_e1 > w_e2) ? w_e1 : w_e2;
            r_wid1  <= (w_e1 > w_e2) ? w_e2 : w_e1;
            r_side1 <= i_side;
        end
    end

    // Stage 2: area, band checks, aspect ratio by cross-multiplication
    assign w_len   = (LEN_W+3)'(r_len1);
    assign w_wid5  = ((LEN_W+3)'(r_wid1) << 2) + (LEN_W+3)'(r_wid1);
    assign w_len10 = ((LEN_W+5)'(r_len1) << 3) + ((LEN_W+5)'(r_len1) << 1);
    assign w_wid13 = ((LEN_W+5)'(r_wid1) << 3) + ((LEN_W+5)'(r_wid1) << 2)
                   + (LEN_W+5)'(r_wid1);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_len2   <= r_len1;
            r_wid2   <= r_wid1;
            r_area2  <= AREA_W'(r_len1) * AREA_W'(r_wid1);
            r_base2  <= r_side1.pts_ok && r_side1.hgt_ok &&
                        (r_wid1 > i_cfg.width_min) && (r_wid1 < i_cfg.width_max) &&
                        (r_len1 > i_cfg.length_min) && (r_len1 < i_cfg.length_max);
            r_long2  <= (r_len1 > RATIO_LEN);
            r_ratio2 <= (w_len10 > w_wid13) && (w_len < w_wid5);
            r_side2  <= r_side1;
        end
    end

    // Stage 3: area limit, signed area * height
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_len3  <= r_len2;
            r_wid3  <= r_wid2;
            r_mass3 <= $signed({1'b0, r_area2}) * r_side2.height;
            r_pre3  <= r_base2 && (r_area2 < i_cfg.area_max) &&
                       (!r_long2 || r_ratio2);
            r_npts3 <= r_side2.npts;
        end
    end

    // Stage 4: npts * 2^24 > 8 * area * height
    assign w_lhs = $signed(CMP_W'(r_npts3) << PTS_SHIFT);
    assign w_rhs = CMP_W'(r_mass3) <<< MASS_SHIFT;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ok4  <= r_pre3 && (w_lhs > w_rhs);
            r_len4 <= r_len3;
            r_wid4 <= r_wid3;
        end
    end

    assign o_vld       = r_vld[3];
    assign o_promising = r_ok4;
    assign o_length    = r_len4;
    assign o_width     = r_wid4;

endmodule
`default_nettype wire

// ===== rtl/core/box_shape_rule_check_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// box_shape_rule_check_unit
// Shape rule check of fitted lidar cluster boxes with APB-configured bounds.
// ---------------------------------------------------------------------------
// Takes one cluster transfer per cycle unless stalled and returns one verdict
// transfer per cluster, in order, after 3 front stages (deltas, squares,
// sums), 17 square-root stages (one root bit each) and 4 rule stages ending
// in the output register. The whole pipeline advances together; i_in.ready
// is low only while a verdict sits in the output register and o_out.ready
// is low. Registers must be written by the user over APB only while no cluster
// is in flight; the unit does not enforce it. Reads return the stored value.
// ---------------------------------------------------------------------------
module box_shape_rule_check_unit
    import bsrc_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    bsrc_in_if.sink                 i_in,
    bsrc_out_if.source              o_out,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    t_bsrc_cfg         w_cfg;
    logic              w_adv;
    logic              w_front_vld;
    logic [SQ_W-1:0]   w_sum1, w_sum2;
    t_bsrc_side        w_front_side;
    logic [ROOT_W-1:0] w_root1, w_root2;
    logic              w_out_vld;

    logic [SQRT_STEPS-1:0] r_sq_vld;
    t_bsrc_side            r_sq_side [SQRT_STEPS];

    // Global advance: move unless a result waits on a stalled sink
    assign w_adv      = !w_out_vld || o_out.ready;
    assign i_in.ready = w_adv;

    bsrc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    bsrc_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (i_in.valid),
        .i_ax    (i_in.corner_a_x),
        .i_ay    (i_in.corner_a_y),
        .i_bx    (i_in.corner_b_x),
        .i_by    (i_in.corner_b_y),
        .i_cx    (i_in.corner_c_x),
        .i_cy    (i_in.corner_c_y),
        .i_top   (i_in.top_height),
        .i_npts  (i_in.point_count),
        .i_cfg   (w_cfg),
        .o_vld   (w_front_vld),
        .o_sum1  (w_sum1),
        .o_sum2  (w_sum2),
        .o_side  (w_front_side)
    );

    bsrc_isqrt u_sqrt1 (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_n    (w_sum1),
        .o_root (w_root1)
    );

    bsrc_isqrt u_sqrt2 (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_n    (w_sum2),
        .o_root (w_root2)
    );

    // Valid and side data delay matching the root pipelines
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld <= '0;
        end else if (w_adv) begin
            r_sq_vld <= {r_sq_vld[SQRT_STEPS-2:0], w_front_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sq_side[0] <= w_front_side;
            for (int i = 1; i < SQRT_STEPS; i++) begin
                r_sq_side[i] <= r_sq_side[i-1];
            end
        end
    end

    bsrc_rules u_rules (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_adv),
        .i_vld       (r_sq_vld[SQRT_STEPS-1]),
        .i_root1     (w_root1),
        .i_root2     (w_root2),
        .i_side      (r_sq_side[SQRT_STEPS-1]),
        .i_cfg       (w_cfg),
        .o_vld       (w_out_vld),
        .o_promising (o_out.promising),
        .o_length    (o_out.box_length),
        .o_width     (o_out.box_width)
    );

    assign o_out.valid = w_out_vld;

endmodule
`default_nettype wire

// ===== verif/bsrc_verdict_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bsrc_verdict_checker
// Watches the cluster and verdict channels and the APB port of the box shape
// rule check unit. It keeps its own copy of the rule bounds, predicts the
// verdict of every accepted cluster and compares each verdict transfer with
// the oldest prediction, field by field.
// ---------------------------------------------------------------------------
module bsrc_verdict_checker
    import bsrc_pkg::*;
#(
    parameter int COORD_W = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    bsrc_in_if                      i_mon_in,
    bsrc_out_if                     i_mon_out,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic               pready,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output int                      o_mismatch_count,
    output int                      o_outstanding
);

    typedef struct packed {
        logic        promising;
        logic [15:0] box_length;
        logic [15:0] box_width;
    } t_verdict;

    t_bsrc_cfg bounds;
    t_verdict  verdict_q[$];
    int        mismatches = 0;
    int        pending    = 0;

    assign o_mismatch_count = mismatches;
    assign o_outstanding    = pending;

    // Edge length in Q8.8: floor root of the squared clamped deltas, saturated
    function automatic logic [15:0] edge_q88(longint x0, longint y0, longint x1, longint y1);
        longint          dx;
        longint          dy;
        longint unsigned sum_sq;
        longint unsigned root;
        longint unsigned trial;
        dx = x0 - x1;
        dy = y0 - y1;
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        if (dx > 65536) dx = 65536;
        if (dy > 65536) dy = 65536;
        sum_sq = dx * dx + dy * dy;
        // bitwise root search, largest bit first
        root = 0;
        for (int b = 17; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= sum_sq) root = trial;
        end
        return (root > 65535) ? 16'hFFFF : root[15:0];
    endfunction

    function automatic t_verdict predict_verdict(t_bsrc_cfg c, longint ax, longint ay,
                                                 longint bx, longint by, longint cx,
                                                 longint cy, longint top, longint npts);
        longint   e1;
        longint   e2;
        longint   len;
        longint   wid;
        longint   hgt;
        longint   area;
        longint   mass8;
        t_verdict v;
        e1   = edge_q88(ax, ay, bx, by);
        e2   = edge_q88(cx, cy, bx, by);
        len  = (e1 > e2) ? e1 : e2;
        wid  = (e1 > e2) ? e2 : e1;
        hgt  = top + longint'(c.sensor_mount_height);
        area = len * wid;
        v.promising  = 1'b0;
        v.box_length = len[15:0];
        v.box_width  = wid[15:0];
        if (npts >= longint'(MIN_POINTS) &&
            hgt > longint'(c.height_min) && hgt < longint'(c.height_max) &&
            wid > longint'(c.width_min) && wid < longint'(c.width_max) &&
            len > longint'(c.length_min) && len < longint'(c.length_max) &&
            area < longint'(c.area_max)) begin
            // point density: count * 2^24 against 8 * area * height, signed
            mass8 = area * hgt * 8;
            if (npts * 64'sd16777216 > mass8) begin
                // long boxes also need a sane aspect ratio
                if (len > longint'(RATIO_LEN))
                    v.promising = (10 * len > 13 * wid) && (len < 5 * wid);
                else
                    v.promising = 1'b1;
            end
        end
        return v;
    endfunction

    always @(posedge i_clk) begin
        t_verdict got;
        t_verdict want;
        if (!i_rst_n) begin
            bounds.height_min          = RST_HEIGHT_MIN;
            bounds.height_max          = RST_HEIGHT_MAX;
            bounds.width_min           = RST_WIDTH_MIN;
            bounds.width_max           = RST_WIDTH_MAX;
            bounds.length_min          = RST_LENGTH_MIN;
            bounds.length_max          = RST_LENGTH_MAX;
            bounds.area_max            = RST_AREA_MAX;
            bounds.sensor_mount_height = RST_SENSOR_MOUNT;
            verdict_q.delete();
        end else begin
            // verdict transfer against the oldest prediction
            if (i_mon_out.valid === 1'b1 && i_mon_out.ready === 1'b1) begin
                got.promising  = i_mon_out.promising;
                got.box_length = i_mon_out.box_length;
                got.box_width  = i_mon_out.box_width;
                if (verdict_q.size() == 0) begin
                    $error("verdict transfer with none expected: promising=%0d length=%0d width=%0d",
                           got.promising, got.box_length, got.box_width);
                    mismatches++;
                end else begin
                    want = verdict_q.pop_front();
                    if (got.promising !== want.promising) begin
                        $error("promising: expected %0d, actual %0d", want.promising,
                               got.promising);
                        mismatches++;
                    end
                    if (got.box_length !== want.box_length) begin
                        $error("box_length: expected %0d, actual %0d", want.box_length,
                               got.box_length);
                        mismatches++;
                    end
                    if (got.box_width !== want.box_width) begin
                        $error("box_width: expected %0d, actual %0d", want.box_width,
                               got.box_width);
                        mismatches++;
                    end
                end
            end

            // cluster transfer: predict with the bounds in force now
            if (i_mon_in.valid === 1'b1 && i_mon_in.ready === 1'b1) begin
                want = predict_verdict(bounds,
                    longint'(i_mon_in.corner_a_x), longint'(i_mon_in.corner_a_y),
                    longint'(i_mon_in.corner_b_x), longint'(i_mon_in.corner_b_y),
                    longint'(i_mon_in.corner_c_x), longint'(i_mon_in.corner_c_y),
                    longint'(i_mon_in.top_height), longint'(i_mon_in.point_count));
                verdict_q.insert(verdict_q.size(), want);
            end

            // register write; bits above the register width are dropped
            if (psel && penable && pwrite && pready) begin
                case (t_bsrc_reg'(paddr[PADDR_W-1:2]))
                    REG_HEIGHT_MIN:   bounds.height_min          = pwdata[15:0];
                    REG_HEIGHT_MAX:   bounds.height_max          = pwdata[15:0];
                    REG_WIDTH_MIN:    bounds.width_min           = pwdata[15:0];
                    REG_WIDTH_MAX:    bounds.width_max           = pwdata[15:0];
                    REG_LENGTH_MIN:   bounds.length_min          = pwdata[15:0];
                    REG_LENGTH_MAX:   bounds.length_max          = pwdata[15:0];
                    REG_AREA_MAX:     bounds.area_max            = pwdata[31:0];
                    REG_SENSOR_MOUNT: bounds.sensor_mount_height = pwdata[15:0];
                    default: ;
                endcase
            end
        end
        pending = verdict_q.size();
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Stimulus for the box shape rule check unit.
// Resets the unit, runs directed boxes under the reset bounds, then random
// clusters under several bound settings written over APB between phases,
// with random idling on both channels. The checker beside the unit does all
// prediction; this module only drives and gives the verdict.
// ---------------------------------------------------------------------------
module tb_top;
    import bsrc_pkg::*;

    localparam int COORD_W      = 16;
    localparam int PIPE_LATENCY = 24;
    localparam int PHASES       = 7;
    localparam int PHASE_ITEMS  = 128;

    typedef struct {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [15:0]        top;
        logic [15:0]               npts;
    } t_cluster;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int        mismatch_count;
    int        outstanding;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    t_bsrc_cfg cfg_shadow;

    bsrc_in_if #(.COORD_WIDTH(COORD_W)) cluster_ch ();
    bsrc_out_if                         verdict_ch ();

    box_shape_rule_check_unit #(
        .COORD_WIDTH (COORD_W)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cluster_ch),
        .o_out   (verdict_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    bsrc_verdict_checker #(
        .COORD_W (COORD_W)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_mon_in         (cluster_ch),
        .i_mon_out        (verdict_ch),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .pready           (pready),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .o_mismatch_count (mismatch_count),
        .o_outstanding    (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit, far above the slowest correct run
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // verdict side back-pressure
    initial begin
        verdict_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            verdict_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic t_cluster make_cluster(longint ax, longint ay, longint bx, longint by,
                                              longint cx, longint cy, longint top,
                                              longint npts);
        t_cluster k;
        k.ax   = COORD_W'(ax);
        k.ay   = COORD_W'(ay);
        k.bx   = COORD_W'(bx);
        k.by   = COORD_W'(by);
        k.cx   = COORD_W'(cx);
        k.cy   = COORD_W'(cy);
        k.top  = 16'(top);
        k.npts = 16'(npts);
        return k;
    endfunction

    // a value on, just beside or between two exclusive bounds
    function automatic int near_bound(int lo, int hi);
        int sel;
        sel = int'($urandom_range(0, 6));
        case (sel)
            0: return lo - 1;
            1: return lo;
            2: return lo + 1;
            3: return hi - 1;
            4: return hi;
            5: return hi + 1;
            default: return (hi > lo) ? lo + int'($urandom_range(0, hi - lo)) : lo;
        endcase
    endfunction

    function automatic int clip(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic t_cluster rand_cluster(t_bsrc_cfg c);
        t_cluster k;
        int       mode;
        int       bx;
        int       by;
        int       e1x;
        int       e1y;
        int       e2x;
        int       e2y;
        int       r;
        int       l;
        int       w;
        int       h;
        mode   = int'($urandom_range(0, 9));
        bx     = int'($urandom_range(0, 8000)) - 4000;
        by     = int'($urandom_range(0, 8000)) - 4000;
        // noise: every field fully random
        k.ax   = COORD_W'($urandom());
        k.ay   = COORD_W'($urandom());
        k.bx   = COORD_W'($urandom());
        k.by   = COORD_W'($urandom());
        k.cx   = COORD_W'($urandom());
        k.cy   = COORD_W'($urandom());
        k.top  = 16'($urandom());
        k.npts = 16'($urandom());
        if (mode <= 5) begin
            // roughly rectangular box of plausible size and orientation
            e1x = int'($urandom_range(0, 2400)) - 1200;
            e1y = int'($urandom_range(0, 2400)) - 1200;
            r   = int'($urandom_range(1, 8));
            e2x = -e1y * r / 8 + int'($urandom_range(0, 40)) - 20;
            e2y =  e1x * r / 8 + int'($urandom_range(0, 40)) - 20;
            if ($urandom_range(0, 1)) begin
                l = e1x; e1x = e2x; e2x = l;
                l = e1y; e1y = e2y; e2y = l;
            end
            k = make_cluster(bx + e1x, by + e1y, bx, by, bx + e2x, by + e2y,
                             int'($urandom_range(0, 1200)) - 500,
                             ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 600));
        end else if (mode <= 7) begin
            // axis-aligned box with edges and height right at the bounds
            l = clip(near_bound(c.length_min, c.length_max), 0, 32767);
            w = clip(near_bound(c.width_min, c.width_max), 0, 32767);
            h = near_bound(c.height_min, c.height_max) - int'(c.sensor_mount_height);
            if ($urandom_range(0, 1))
                k = make_cluster(bx + l, by, bx, by, bx, by + w, clip(h, -32768, 32767), 0);
            else
                k = make_cluster(bx, by - w, bx, by, bx - l, by, clip(h, -32768, 32767), 0);
            k.npts = ($urandom_range(0, 3) == 0) ? 16'(near_bound(25, 25))
                                                 : 16'($urandom_range(0, 4000));
        end
        return k;
    endfunction

    task automatic send_cluster(t_cluster k);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            cluster_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        cluster_ch.valid      <= 1'b1;
        cluster_ch.corner_a_x <= k.ax;
        cluster_ch.corner_a_y <= k.ay;
        cluster_ch.corner_b_x <= k.bx;
        cluster_ch.corner_b_y <= k.by;
        cluster_ch.corner_c_x <= k.cx;
        cluster_ch.corner_c_y <= k.cy;
        cluster_ch.top_height <= k.top;
        cluster_ch.point_count <= k.npts;
        do @(posedge i_clk); while (cluster_ch.ready !== 1'b1);
    endtask

    // stop sending and wait until every verdict is back
    task automatic drain_verdicts();
        @(negedge i_clk);
        cluster_ch.valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (PIPE_LATENCY + 2) @(negedge i_clk);
    endtask

    task automatic apb_write(t_bsrc_reg idx, logic [31:0] val);
        logic [31:0] wdata;
        wdata = val;
        // junk above a 16 bit register must be ignored
        if (idx != REG_AREA_MAX) wdata[31:16] = 16'($urandom());
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic program_bounds(t_bsrc_cfg c);
        drain_verdicts();
        apb_write(REG_HEIGHT_MIN,   32'(c.height_min));
        apb_write(REG_HEIGHT_MAX,   32'(c.height_max));
        apb_write(REG_WIDTH_MIN,    32'(c.width_min));
        apb_write(REG_WIDTH_MAX,    32'(c.width_max));
        apb_write(REG_LENGTH_MIN,   32'(c.length_min));
        apb_write(REG_LENGTH_MAX,   32'(c.length_max));
        apb_write(REG_AREA_MAX,     c.area_max);
        apb_write(REG_SENSOR_MOUNT, 32'(c.sensor_mount_height));
        cfg_shadow = c;
    endtask

    initial begin
        t_bsrc_cfg c;
        int        random_sent;
        random_sent            = 0;
        i_rst_n                = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        cluster_ch.valid       = 1'b0;
        cluster_ch.corner_a_x  = '0;
        cluster_ch.corner_a_y  = '0;
        cluster_ch.corner_b_x  = '0;
        cluster_ch.corner_b_y  = '0;
        cluster_ch.corner_c_x  = '0;
        cluster_ch.corner_c_y  = '0;
        cluster_ch.top_height  = '0;
        cluster_ch.point_count = '0;
        cfg_shadow.height_min          = RST_HEIGHT_MIN;
        cfg_shadow.height_max          = RST_HEIGHT_MAX;
        cfg_shadow.width_min           = RST_WIDTH_MIN;
        cfg_shadow.width_max           = RST_WIDTH_MAX;
        cfg_shadow.length_min          = RST_LENGTH_MIN;
        cfg_shadow.length_max          = RST_LENGTH_MAX;
        cfg_shadow.area_max            = RST_AREA_MAX;
        cfg_shadow.sensor_mount_height = RST_SENSOR_MOUNT;
        send_idle_pct = 15;
        recv_idle_pct = 60;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed boxes under the reset bounds
        send_cluster(make_cluster(512, 0, 0, 0, 0, 256, 0, 100));      // clean pass
        send_cluster(make_cluster(512, 0, 0, 0, 0, 256, 0, 24));       // too few points
        send_cluster(make_cluster(512, 0, 0, 0, 0, 256, 0, 25));       // fewest points allowed
        send_cluster(make_cluster(0, 256, 0, 0, 512, 0, 0, 100));      // edges swapped
        send_cluster(make_cluster(1024, 0, 0, 0, 0, 256, 0, 100));     // long, ratio inside
        send_cluster(make_cluster(1024, 0, 0, 0, 0, 150, 0, 100));     // long, too slender
        send_cluster(make_cluster(768, 0, 0, 0, 0, 256, 0, 100));      // right at 3 m
        send_cluster(make_cluster(769, 0, 0, 0, 0, 256, 0, 100));      // just over 3 m
        send_cluster(make_cluster(300, 0, 0, 0, 0, 300, 0, 100));      // equal edges
        send_cluster(make_cluster(300, 400, 0, 0, -400, 300, 0, 100)); // rotated, exact roots
        send_cluster(make_cluster(512, 0, 0, 0, 0, 256, -1000, 100));  // negative height
        send_cluster(make_cluster(32767, 32767, -32768, -32768, 32767, -32768, 0, 100));
        send_cluster(make_cluster(-32768, -32768, 32767, 32767, -32768, 32767, 0, 100));
        send_cluster(make_cluster(-32768, -32768, -32768, -32768, -32768, -32768,
                                  -32768, 0));
        send_cluster(make_cluster(32767, 32767, 32767, 32767, 32767, 32767, 32767, 65535));
        send_cluster(make_cluster(512, 0, 0, 0, 0, 256, 32767, 65535));
        send_cluster(make_cluster(512, 0, 0, 0, 0, 256, -32768, 65535));
        send_cluster(make_cluster(1000, 0, 0, 0, 0, 800, 0, 65535));   // ratio below 1.3

        // random phases, each under its own bounds
        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                case (p)
                    2, 6: begin
                        // wide open bounds
                        c.height_min          = -16'sd32768;
                        c.height_max          = 16'sd32767;
                        c.width_min           = 16'd0;
                        c.width_max           = 16'hFFFF;
                        c.length_min          = 16'd0;
                        c.length_max          = 16'hFFFF;
                        c.area_max            = 32'hFFFF_FFFF;
                        c.sensor_mount_height = (p == 2) ? -16'sd32768 : 16'sd32767;
                    end
                    4: begin
                        // nothing can pass
                        c.height_min          = 16'sd32767;
                        c.height_max          = -16'sd32768;
                        c.width_min           = 16'hFFFF;
                        c.width_max           = 16'd0;
                        c.length_min          = 16'hFFFF;
                        c.length_max          = 16'd0;
                        c.area_max            = 32'd0;
                        c.sensor_mount_height = 16'sd32767;
                    end
                    default: begin
                        c.height_min          = 16'(int'($urandom_range(0, 768)) - 256);
                        c.height_max          = 16'($urandom_range(300, 2000));
                        c.width_min           = 16'($urandom_range(0, 300));
                        c.width_max           = 16'($urandom_range(200, 2000));
                        c.length_min          = 16'($urandom_range(0, 600));
                        c.length_max          = 16'($urandom_range(600, 6000));
                        c.area_max            = $urandom_range(0, 32'h0080_0000);
                        c.sensor_mount_height = 16'(int'($urandom_range(0, 1024)) - 512);
                    end
                endcase
                program_bounds(c);
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // idle mix: slow reader, then slow writer, then full rate
                if (random_sent < 300) begin
                    send_idle_pct = 15;
                    recv_idle_pct = 60;
                end else if (random_sent < 600) begin
                    send_idle_pct = 60;
                    recv_idle_pct = 15;
                end else begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                send_cluster(rand_cluster(cfg_shadow));
                random_sent++;
            end
        end

        drain_verdicts();
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
